// ----- rtl/aeg_pkg.sv -----
// Shared types, constants and the control program of the envelope generator.
`default_nettype none

package aeg_pkg;

    localparam int unsigned LEVEL_W = 20;
    localparam int unsigned PC_W    = 4;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [2:0] CFG_ATTACK_RATE   = 3'd0;
    localparam logic [2:0] CFG_DCY_MULT      = 3'd1;
    localparam logic [2:0] CFG_SUSTAIN_LEVEL = 3'd2;
    localparam logic [2:0] CFG_REL_MULT      = 3'd3;
    localparam logic [2:0] CFG_GAIN_ENABLE   = 3'd4;

    localparam int unsigned CFG_DATA_W = 19;

    localparam logic [LEVEL_W-1:0] ENV_PEAK  = 20'd524272;
    localparam logic [LEVEL_W-1:0] ENV_FLOOR = 20'd16;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] gain;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] env_out;
        logic               in_decay;
        logic               silent;
    } t_out_item;

    typedef struct packed {
        logic [18:0]        attack_rate;
        logic [14:0]        dcy_mult;
        logic signed [15:0] sustain_level;
        logic [14:0]        rel_mult;
        logic               gain_enable;
    } t_cfg;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SQR,
        MUL_GAIN,
        MUL_DECAY,
        MUL_REL
    } t_mul;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_LOAD_Y,
        UOP_LOAD_YG,
        UOP_SAT,
        UOP_ATTACK,
        UOP_DECAY,
        UOP_RELEASE,
        UOP_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_GAIN,
        COND_NO_GATE,
        COND_DECAY
    } t_cond;

    typedef struct packed {
        t_mul            mul;
        t_uop            op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic no_gain;
        logic no_gate;
        logic decay;
    } t_flags;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    localparam logic [PC_W-1:0] PC_SAT     = 4'd4;
    localparam logic [PC_W-1:0] PC_DECAY   = 4'd7;
    localparam logic [PC_W-1:0] PC_RELEASE = 4'd9;
    localparam logic [PC_W-1:0] PC_EMIT    = 4'd11;
    localparam logic [PC_W-1:0] PC_ZERO    = 4'd0;

    function automatic t_uword aeg_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{mul: MUL_NONE, op: UOP_NOP, cond: COND_ALWAYS, target: PC_EMIT};
        case (pc)
            4'd0:  w = '{mul: MUL_SQR,   op: UOP_NOP,     cond: COND_NEXT,    target: PC_ZERO};
            4'd1:  w = '{mul: MUL_NONE,  op: UOP_LOAD_Y,  cond: COND_NO_GAIN, target: PC_SAT};
            4'd2:  w = '{mul: MUL_GAIN,  op: UOP_NOP,     cond: COND_NEXT,    target: PC_ZERO};
            4'd3:  w = '{mul: MUL_NONE,  op: UOP_LOAD_YG, cond: COND_NEXT,    target: PC_ZERO};
            4'd4:  w = '{mul: MUL_NONE,  op: UOP_SAT,     cond: COND_NO_GATE, target: PC_RELEASE};
            4'd5:  w = '{mul: MUL_NONE,  op: UOP_NOP,     cond: COND_DECAY,   target: PC_DECAY};
            4'd6:  w = '{mul: MUL_NONE,  op: UOP_ATTACK,  cond: COND_ALWAYS,  target: PC_EMIT};
            4'd7:  w = '{mul: MUL_DECAY, op: UOP_NOP,     cond: COND_NEXT,    target: PC_ZERO};
            4'd8:  w = '{mul: MUL_NONE,  op: UOP_DECAY,   cond: COND_ALWAYS,  target: PC_EMIT};
            4'd9:  w = '{mul: MUL_REL,   op: UOP_NOP,     cond: COND_NEXT,    target: PC_ZERO};
            4'd10: w = '{mul: MUL_NONE,  op: UOP_RELEASE, cond: COND_NEXT,    target: PC_ZERO};
            4'd11: w = '{mul: MUL_NONE,  op: UOP_EMIT,    cond: COND_NEXT,    target: PC_ZERO};
            default: w = '{mul: MUL_NONE, op: UOP_NOP, cond: COND_ALWAYS, target: PC_EMIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/aeg_sequencer.sv -----
// Step counter and program table that drive the envelope datapath.
`default_nettype none

module aeg_sequencer import aeg_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_flags i_flags,
    input  wire logic   i_slot_free,
    output t_uword      o_uword,
    output logic        o_emit,
    output logic        o_idle
);

    t_seq_state      r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          w_word;
    logic            w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_pc    <= PC_ZERO;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    always_comb begin
        w_word = aeg_rom(r_pc);
        case (w_word.cond)
            COND_NEXT:    w_take = 1'b0;
            COND_ALWAYS:  w_take = 1'b1;
            COND_NO_GAIN: w_take = i_flags.no_gain;
            COND_NO_GATE: w_take = i_flags.no_gate;
            COND_DECAY:   w_take = i_flags.decay;
            default:      w_take = 1'b0;
        endcase
        n_state = r_state;
        n_pc    = r_pc;
        o_emit  = 1'b0;
        o_idle  = 1'b0;
        o_uword = '{mul: MUL_NONE, op: UOP_NOP, cond: COND_NEXT, target: PC_ZERO};
        case (r_state)
            SEQ_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_state = SEQ_RUN;
                    n_pc    = PC_ZERO;
                end
            end
            SEQ_RUN: begin
                o_uword = w_word;
                if (w_word.op == UOP_EMIT) begin
                    if (i_slot_free) begin
                        o_emit  = 1'b1;
                        n_state = SEQ_IDLE;
                        n_pc    = PC_ZERO;
                    end
                end else if (w_take) begin
                    n_pc = w_word.target;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            default: begin
                n_state = SEQ_IDLE;
                n_pc    = PC_ZERO;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/aeg_datapath.sv -----
// Envelope state, shared multiplier and the step operations of the envelope generator.
`default_nettype none

module aeg_datapath import aeg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_start,
    input  wire logic               i_note_on,
    input  wire logic               i_note_off,
    input  wire logic signed [15:0] i_gain,
    input  wire t_uword             i_uword,
    output t_flags                  o_flags,
    output t_out_item               o_result
);

    localparam logic signed [19:0] Y_MAX = 20'sd32767;
    localparam logic signed [19:0] Y_MIN = -20'sd32768;

    logic [LEVEL_W-1:0] r_level;
    logic               r_decay;
    logic               r_gate;
    logic signed [15:0] r_gain;
    logic signed [37:0] r_prod;
    logic signed [19:0] r_y;
    logic signed [15:0] r_env;

    logic [15:0]        w_mag;
    logic [LEVEL_W-1:0] w_sus;
    logic [LEVEL_W-1:0] w_diff;
    logic [LEVEL_W:0]   w_attack_sum;
    logic [LEVEL_W-1:0] w_scaled;
    logic signed [19:0] w_sq;
    logic signed [20:0] w_ma;
    logic signed [16:0] w_mb;
    logic signed [37:0] w_prod;

    always_comb begin
        w_mag        = i_cfg.sustain_level[15] ? 16'(-i_cfg.sustain_level)
                                               : 16'(i_cfg.sustain_level);
        w_sus        = {w_mag, 4'b0000};
        w_diff       = r_level - w_sus;
        w_attack_sum = {1'b0, r_level} + {2'b00, i_cfg.attack_rate};
        w_scaled     = r_prod[34:15];
        w_sq         = i_cfg.sustain_level[15] ? -{3'b000, r_prod[31:15]}
                                               : {3'b000, r_prod[31:15]};
        case (i_uword.mul)
            MUL_SQR: begin
                w_ma = {5'b00000, r_level[19:4]};
                w_mb = {1'b0, r_level[19:4]};
            end
            MUL_GAIN: begin
                w_ma = {r_y[19], r_y};
                w_mb = {r_gain[15], r_gain};
            end
            MUL_DECAY: begin
                w_ma = {1'b0, w_diff};
                w_mb = {2'b00, i_cfg.dcy_mult};
            end
            MUL_REL: begin
                w_ma = {1'b0, r_level};
                w_mb = {2'b00, i_cfg.rel_mult};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = w_ma * w_mb;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_gain <= i_gain;
        end
        if (i_uword.mul != MUL_NONE) begin
            r_prod <= w_prod;
        end
        case (i_uword.op)
            UOP_LOAD_Y:  r_y <= w_sq;
            UOP_LOAD_YG: r_y <= r_prod[34:15];
            UOP_SAT: begin
                if (r_y > Y_MAX) begin
                    r_env <= 16'sh7FFF;
                end else if (r_y < Y_MIN) begin
                    r_env <= -16'sh8000;
                end else begin
                    r_env <= r_y[15:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_decay <= 1'b0;
            r_gate  <= 1'b0;
        end else if (i_note_on) begin
            r_level <= '0;
            r_decay <= 1'b0;
            r_gate  <= 1'b1;
        end else if (i_note_off) begin
            r_gate <= 1'b0;
        end else begin
            case (i_uword.op)
                UOP_ATTACK: begin
                    if (w_attack_sum >= {1'b0, ENV_PEAK}) begin
                        r_level <= ENV_PEAK;
                        r_decay <= 1'b1;
                    end else begin
                        r_level <= w_attack_sum[LEVEL_W-1:0];
                    end
                end
                UOP_DECAY: begin
                    if (r_level > w_sus) begin
                        r_level <= w_sus + w_scaled;
                    end else begin
                        r_level <= w_sus;
                    end
                end
                UOP_RELEASE: begin
                    r_level <= (w_scaled < ENV_FLOOR) ? '0 : w_scaled;
                    r_decay <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_flags.no_gain   = !i_cfg.gain_enable;
    assign o_flags.no_gate   = !r_gate;
    assign o_flags.decay     = r_decay;
    assign o_result.env_out  = r_env;
    assign o_result.in_decay = r_decay;
    assign o_result.silent   = !r_gate && (r_level == '0);

endmodule

`default_nettype wire

// ----- rtl/adsr_envelope_generator_unit.sv -----
// Top level of the envelope generator: handshakes, configuration registers and result register.
//
// Input items arrive on i_in_valid/o_in_ready with payload i_in_data. A note-on or
// note-off is applied at its transfer and produces no result.
// A sample tick starts the control program, which runs on one shared multiplier:
// 6 to 9 program steps depending on the envelope phase and on gain_enable. The result is
// loaded into the output register at the last step, which holds while that register is full.
// o_in_ready returns in the cycle after that load, so a new tick is not taken until
// the last one's result has been loaded.
// Results leave on o_out_valid/i_out_ready from a single output register. A waiting
// result does not block new input; only a finished tick that finds the output
// register still full holds at its last step until the receiver takes the transfer.
// Configuration writes take effect at the edge where i_cfg_we is high and are
// expected only while the block is idle.
// Synchronous reset clears the envelope level, the phase flag, the gate, all
// configuration registers and the output valid flag, and returns the program to idle.
`default_nettype none

module adsr_envelope_generator_unit import aeg_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic      w_accept;
    logic      w_start;
    logic      w_note_on;
    logic      w_note_off;
    logic      w_slot_free;
    logic      w_emit;
    logic      w_idle;
    t_uword    w_uword;
    t_flags    w_flags;
    t_out_item w_result;

    assign o_in_ready  = w_idle;
    assign w_accept    = i_in_valid && w_idle;
    assign w_start     = w_accept && (i_in_data.opcode == OP_TICK);
    assign w_note_on   = w_accept && (i_in_data.opcode == OP_NOTE_ON);
    assign w_note_off  = w_accept && (i_in_data.opcode == OP_NOTE_OFF);
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ATTACK_RATE:   r_cfg.attack_rate   <= i_cfg_data[18:0];
                CFG_DCY_MULT:      r_cfg.dcy_mult      <= i_cfg_data[14:0];
                CFG_SUSTAIN_LEVEL: r_cfg.sustain_level <= i_cfg_data[15:0];
                CFG_REL_MULT:      r_cfg.rel_mult      <= i_cfg_data[14:0];
                CFG_GAIN_ENABLE:   r_cfg.gain_enable   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= w_result;
        end
    end

    aeg_sequencer u_sequencer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_flags     (w_flags),
        .i_slot_free (w_slot_free),
        .o_uword     (w_uword),
        .o_emit      (w_emit),
        .o_idle      (w_idle)
    );

    aeg_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_start    (w_start),
        .i_note_on  (w_note_on),
        .i_note_off (w_note_off),
        .i_gain     (i_in_data.gain),
        .i_uword    (w_uword),
        .o_flags    (w_flags),
        .o_result   (w_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef ASSERT_OFF
    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || i_out_ready))
        else $error("result loaded while the output register was still full");

    a_tick_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !o_in_ready)
        else $error("input still ready in the cycle after a tick transfer");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_emit))
        else $error("output valid rose without a finished tick");
`endif

endmodule

`default_nettype wire

// ----- dv/adsr_envelope_checker.sv -----
// Checker for the envelope generator: predicts each tick's result and compares every output transfer.
module adsr_envelope_checker import aeg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_mismatches
);

    t_cfg         cfg;
    logic [19:0]  env_level;
    logic         env_decaying;
    logic         env_gate;
    t_out_item    expected_env[$];

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item   want;
        t_out_item   got;
        logic [15:0] base;
        longint      y;
        int          mag;
        logic [19:0] sus;
        logic [63:0] prod;
        logic [20:0] sum;
        if (!i_rst_n) begin
            cfg          = '0;
            env_level    = '0;
            env_decaying = 1'b0;
            env_gate     = 1'b0;
            expected_env.delete();
            o_mismatches = 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ATTACK_RATE:   cfg.attack_rate   = i_cfg_data[18:0];
                    CFG_DCY_MULT:      cfg.dcy_mult      = i_cfg_data[14:0];
                    CFG_SUSTAIN_LEVEL: cfg.sustain_level = i_cfg_data[15:0];
                    CFG_REL_MULT:      cfg.rel_mult      = i_cfg_data[14:0];
                    CFG_GAIN_ENABLE:   cfg.gain_enable   = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_env.size() == 0) begin
                    report_mismatch($sformatf("result transfer with no tick waiting (env_out %0d)",
                                              got.env_out));
                end else begin
                    want = expected_env.pop_front();
                    if (got.env_out !== want.env_out)
                        report_mismatch($sformatf("env_out got %0d want %0d",
                                                  got.env_out, want.env_out));
                    if (got.in_decay !== want.in_decay)
                        report_mismatch($sformatf("in_decay got %b want %b",
                                                  got.in_decay, want.in_decay));
                    if (got.silent !== want.silent)
                        report_mismatch($sformatf("silent got %b want %b",
                                                  got.silent, want.silent));
                end
            end

            if (i_in_valid && i_in_ready) begin
                case (i_in_data.opcode)
                    OP_NOTE_ON: begin
                        env_gate     = 1'b1;
                        env_level    = '0;
                        env_decaying = 1'b0;
                    end
                    OP_NOTE_OFF: begin
                        env_gate = 1'b0;
                    end
                    OP_TICK: begin
                        // The output is formed from the level as it stands before the step.
                        base = env_level[19:4];
                        y    = longint'((64'(base) * 64'(base)) >> 15);
                        if (cfg.sustain_level < 0)
                            y = -y;
                        if (cfg.gain_enable)
                            y = (y * longint'(i_in_data.gain)) >>> 15;
                        if (y > 32767)
                            y = 32767;
                        else if (y < -32768)
                            y = -32768;
                        want.env_out = y[15:0];

                        if (env_gate) begin
                            if (env_decaying) begin
                                mag = cfg.sustain_level;
                                if (mag < 0)
                                    mag = -mag;
                                sus = 20'(mag << 4);
                                if (env_level > sus) begin
                                    prod      = 64'(env_level - sus) * 64'(cfg.dcy_mult);
                                    env_level = sus + 20'(prod >> 15);
                                end else begin
                                    env_level = sus;
                                end
                            end else begin
                                sum = 21'(env_level) + 21'(cfg.attack_rate);
                                if (sum >= 21'(ENV_PEAK)) begin
                                    env_level    = ENV_PEAK;
                                    env_decaying = 1'b1;
                                end else begin
                                    env_level = sum[19:0];
                                end
                            end
                        end else begin
                            prod = (64'(env_level) * 64'(cfg.rel_mult)) >> 15;
                            env_level    = (prod < 64'(ENV_FLOOR)) ? 20'd0 : prod[19:0];
                            env_decaying = 1'b0;
                        end

                        want.in_decay = env_decaying;
                        want.silent   = !env_gate && (env_level == 0);
                        expected_env.push_back(want);
                    end
                    default: ;
                endcase
            end
            o_pending <= expected_env.size();
        end
    end

endmodule

// ----- dv/adsr_envelope_generator_unit_tb.sv -----
// Testbench top for the envelope generator: drives notes, ticks and settings and gives the verdict.
module adsr_envelope_generator_unit_tb;
    import aeg_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we = 1'b0;
    logic [2:0]            cfg_idx = CFG_ATTACK_RATE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int pending;
    int mismatches;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int items_sent = 0;

    always #10 clk = ~clk;

    adsr_envelope_generator_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    adsr_envelope_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic send(input logic [1:0] op, input logic [15:0] gain);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{opcode: op, gain: gain};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Waits until every tick's result has been taken and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] attack,
                                 input logic [CFG_DATA_W-1:0] decay,
                                 input logic [CFG_DATA_W-1:0] sustain,
                                 input logic [CFG_DATA_W-1:0] rel,
                                 input logic [CFG_DATA_W-1:0] gain_en);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [2:0]            idxs [5];
        vals[0] = attack;  idxs[0] = CFG_ATTACK_RATE;
        vals[1] = decay;   idxs[1] = CFG_DCY_MULT;
        vals[2] = sustain; idxs[2] = CFG_SUSTAIN_LEVEL;
        vals[3] = rel;     idxs[3] = CFG_REL_MULT;
        vals[4] = gain_en; idxs[4] = CFG_GAIN_ENABLE;
        for (int k = 0; k < 5; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idxs[k];
            cfg_data <= vals[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic play_phrase();
        int held;
        int tail;
        held = ($urandom_range(3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 25);
        tail = $urandom_range(1, 20);
        send(OP_NOTE_ON, 16'($urandom));
        repeat (held) send(OP_TICK, 16'($urandom));
        send(OP_NOTE_OFF, 16'($urandom));
        repeat (tail) send(OP_TICK, 16'($urandom));
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] attack;
        logic [CFG_DATA_W-1:0] decay;
        logic [CFG_DATA_W-1:0] sustain;
        logic [CFG_DATA_W-1:0] rel;
        int                    phase_start;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: nothing moves and the output stays at zero.
        send(OP_TICK, 16'h0000);
        send(OP_UNUSED, 16'hFFFF);
        send(OP_NOTE_ON, 16'h0000);
        send(OP_TICK, 16'h7FFF);
        send(OP_NOTE_OFF, 16'h0000);
        send(OP_TICK, 16'h8000);

        // Full attack in one tick, most negative sustain, full release, gain on.
        settle();
        load_settings(19'd524272, 19'd32767, 19'(16'h8000), 19'd32767, 19'd1);
        send(OP_NOTE_ON, 16'h0000);
        send(OP_TICK, 16'h7FFF);
        send(OP_TICK, 16'h8000);
        send(OP_TICK, 16'h7FFF);
        send(OP_TICK, 16'hFFFF);
        send(OP_TICK, 16'h5555);
        send(OP_NOTE_OFF, 16'h0000);
        send(OP_TICK, 16'h8000);
        send(OP_TICK, 16'hAAAA);

        // Widest attack field, decay straight to sustain, positive sustain, release straight to zero.
        settle();
        load_settings(19'h7FFFF, 19'd0, 19'(16'h7FFF), 19'd0, 19'd0);
        send(OP_NOTE_ON, 16'h0000);
        send(OP_TICK, 16'h0000);
        send(OP_TICK, 16'h0000);
        send(OP_NOTE_OFF, 16'h0000);
        send(OP_TICK, 16'h0000);
        send(OP_TICK, 16'h0000);

        for (int phase = 0; phase < 8; phase++) begin
            settle();
            case ($urandom_range(7))
                0:       attack = 19'd0;
                1:       attack = 19'd524272;
                2:       attack = 19'h7FFFF;
                3:       attack = $urandom_range(1, 20000);
                default: attack = $urandom_range(20000, 300000);
            endcase
            case ($urandom_range(3))
                0:       decay = 19'd0;
                1:       decay = 19'd32767;
                default: decay = 19'($urandom);
            endcase
            case ($urandom_range(5))
                0:       sustain = 19'(16'h8000);
                1:       sustain = 19'(16'h7FFF);
                2:       sustain = 19'(16'h8001);
                3:       sustain = 19'd0;
                default: sustain = 19'($urandom);
            endcase
            case ($urandom_range(3))
                0:       rel = 19'd0;
                1:       rel = 19'd32767;
                default: rel = 19'($urandom);
            endcase
            load_settings(attack, decay, sustain, rel, 19'($urandom));

            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
                default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
            endcase

            phase_start = items_sent;
            while (items_sent - phase_start < 120) begin
                if ($urandom_range(9) == 0)
                    send(2'($urandom_range(3)), 16'($urandom));
                else
                    play_phrase();
            end
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("adsr_envelope_generator_unit_tb: clean");
        else
            $display("adsr_envelope_generator_unit_tb: errors");
        $finish;
    end

    initial begin : watchdog
        #20000000;
        $display("adsr_envelope_generator_unit_tb: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/aeg_pkg.sv
rtl/aeg_sequencer.sv
rtl/aeg_datapath.sv
rtl/adsr_envelope_generator_unit.sv
dv/adsr_envelope_checker.sv
dv/adsr_envelope_generator_unit_tb.sv
